/* hw/rtl/assert_macros.svh */
// Assertion helpers shared by the RTL. Both expect signals named clk and rst
// in the scope where they are used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define RPC_ASSERT(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("response packet checker assertion failed");

// A condition that must hold whenever the antecedent holds.
`define RPC_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("response packet checker assertion failed");

`endif

/* hw/rtl/rpc_pkg.sv */
package rpc_pkg;

  // Largest payload length that is accepted as valid.
  localparam int MaxPayload = 512;

  // Queue between the parser and the result stage.
  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  localparam logic [7:0] SentTypeReset = 8'h02;
  localparam logic [8:0] IndexMax      = 9'h1FF;
  localparam logic [7:0] ErrorCodeMax  = 8'd32;

  // Header type codes that carry a meaning of their own.
  localparam logic [7:0] TYPE_BUSY      = 8'h00;
  localparam logic [7:0] TYPE_CMD_ERROR = 8'h01;
  localparam logic [7:0] TYPE_ECHO_A    = 8'h02;
  localparam logic [7:0] TYPE_ECHO_B    = 8'h04;

  // Continuation flag codes.
  localparam logic [7:0] FLAG_SINGLE = 8'h00;
  localparam logic [7:0] FLAG_FIRST  = 8'h01;
  localparam logic [7:0] FLAG_LAST   = 8'h03;

  typedef enum logic [2:0] {
    ST_HDR_TYPE,
    ST_HDR_CMD_HI,
    ST_HDR_CMD_LO,
    ST_HDR_FLAG,
    ST_HDR_LEN_LO,
    ST_HDR_LEN_HI,
    ST_PAYLOAD,
    ST_CHECK
  } front_state_t;

  typedef enum logic [2:0] {
    STATUS_OK        = 3'd0,
    STATUS_LEN_BAD   = 3'd1,
    STATUS_SUM_BAD   = 3'd2,
    STATUS_BUSY      = 3'd3,
    STATUS_CMD_ERROR = 3'd4,
    STATUS_ECHO      = 3'd5,
    STATUS_UNKNOWN   = 3'd6,
    STATUS_FLAG_SEQ  = 3'd7
  } status_t;

  // One classified byte handed from the parser to the result stage.
  typedef struct packed {
    logic        kind;       // 0 payload byte, 1 checksum byte
    logic [7:0]  data;
    logic [8:0]  index;
    logic [7:0]  ptype;
    logic [15:0] cmd_id;
    logic [7:0]  flag;
    logic [15:0] length;
    logic        len_bad;
    logic        sum_bad;
    logic [31:0] code_mask;
  } q_entry_t;

  typedef struct packed {
    logic valid;
    logic full;
  } q_status_t;

  // Output data word; the last member sits in the lowest bits.
  typedef struct packed {
    logic [2:0]  pad;
    logic        response_complete;
    logic [31:0] error_mask;
    logic [15:0] payload_length;
    logic [7:0]  continuation_flag;
    logic [15:0] command_id;
    logic [7:0]  packet_type;
    status_t     status;
    logic [8:0]  payload_index;
    logic [7:0]  payload_byte;
  } out_data_t;

  localparam int OutDataW = $bits(out_data_t);

endpackage

/* hw/rtl/response_packet_checker_top.sv */
// A byte accepted on the slave side is written into the queue, then into the
// output register when the output is free, and so reaches the master side.
// Throughput: one byte per cycle, sustained as long as the master side drains.
// Header bytes produce no result; payload and checksum bytes produce one each.
// Reset (rst, synchronous, active high) returns the parser to the type byte,
// empties the queue, sets the sent command type to 2 and expects a first packet.
`include "assert_macros.svh"

// The checker is split into a parser, a four-entry queue and a result stage.
//
// The parser (rpc_front) walks the six header bytes, counts payload bytes down
// from the length field, keeps the running 8-bit sum and collects the error
// code mask. Every payload byte and every checksum byte becomes one queue
// transaction that carries the captured header along with it, plus the
// length and checksum verdicts for a checksum byte.
//
// The result stage (rpc_back) owns the sent command type register and the
// continuation sequence bit. It finishes the status priority (length,
// checksum, type, sequence) and loads the output register. Because the queue
// sits between the two, the slave side keeps accepting bytes while a result
// waits on the master side, and only a full queue stalls the input.
module response_packet_checker_top (
  input  logic                         clk,
  input  logic                         rst,
  // Received byte stream.
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [7:0]                   s_tdata,   // rx_byte
  // Sent command type register.
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [7:0]                   cfg_data,  // sent_command_type
  // Result stream; tlast is item_kind and marks the status transaction.
  output logic                         m_tvalid,
  input  logic                         m_tready,
  // Fields from the lowest bit up: payload_byte, payload_index, status,
  // packet_type, command_id, continuation_flag, payload_length, error_mask,
  // response_complete, then three zero bits of padding.
  output logic [rpc_pkg::OutDataW-1:0] m_tdata,
  output logic                         m_tlast
);
  import rpc_pkg::*;

  q_status_t q_stat;
  q_entry_t  q_in;
  q_entry_t  q_head;
  logic      q_push;
  logic      q_pop;
  out_data_t out_word;

  // Short names for the output checks below.
  logic      out_ok;
  logic      out_has_mask;
  logic      out_payload_clean;

  rpc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .q_stat   (q_stat),
    .q_push   (q_push),
    .q_entry  (q_in)
  );

  rpc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_in),
    .pop        (q_pop),
    .head       (q_head),
    .stat       (q_stat)
  );

  rpc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .head      (q_head),
    .stat      (q_stat),
    .pop       (q_pop),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (out_word),
    .m_tlast   (m_tlast)
  );

  assign m_tdata = out_word;

  assign out_ok            = (out_word.status == STATUS_OK);
  assign out_has_mask      = (out_word.error_mask != '0);
  assign out_payload_clean = out_ok && !out_has_mask && !out_word.response_complete;

  // A payload transaction never carries status, mask or completion.
  `RPC_ASSERT_IMPL(a_payload_clean, m_tvalid && !m_tlast, out_payload_clean)
  // Completion is only reported for a clean packet.
  `RPC_ASSERT_IMPL(a_complete_ok, m_tvalid && out_word.response_complete, out_ok)
  // Error codes are only reported with a command error status.
  `RPC_ASSERT_IMPL(a_mask_cmd_err, m_tvalid && out_has_mask, out_word.status == STATUS_CMD_ERROR)
  // A full queue must hold off the input, and nothing is pushed into it.
  `RPC_ASSERT_IMPL(a_full_stall, q_stat.full, !s_tready && !q_push)

endmodule

/* hw/rtl/rpc_front.sv */
module rpc_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [7:0]          s_tdata,
  input  rpc_pkg::q_status_t  q_stat,
  output logic                q_push,
  output rpc_pkg::q_entry_t   q_entry
);
  import rpc_pkg::*;

  front_state_t state, state_next;
  logic [15:0]  remaining;
  logic [7:0]   sum;
  logic [7:0]   ptype;
  logic [15:0]  cmd_id;
  logic [7:0]   flag;
  logic [15:0]  length;
  logic [31:0]  code_mask;
  logic [8:0]   index;

  logic         accept;
  logic [31:0]  code_bit;

  assign s_tready = !q_stat.full;
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    if (s_tdata != 8'd0 && s_tdata <= ErrorCodeMax) begin
      code_bit = 32'd1 << 5'(s_tdata - 8'd1);
    end else begin
      code_bit = '0;
    end
  end

  always_comb begin
    state_next = state;
    if (accept) begin
      case (state)
        ST_HDR_TYPE:   state_next = ST_HDR_CMD_HI;
        ST_HDR_CMD_HI: state_next = ST_HDR_CMD_LO;
        ST_HDR_CMD_LO: state_next = ST_HDR_FLAG;
        ST_HDR_FLAG:   state_next = ST_HDR_LEN_LO;
        ST_HDR_LEN_LO: state_next = ST_HDR_LEN_HI;
        ST_HDR_LEN_HI: begin
          if ({s_tdata, length[7:0]} == 16'd0) begin
            state_next = ST_CHECK;
          end else begin
            state_next = ST_PAYLOAD;
          end
        end
        ST_PAYLOAD: begin
          if (remaining == 16'd1) begin
            state_next = ST_CHECK;
          end
        end
        ST_CHECK:      state_next = ST_HDR_TYPE;
        default:       state_next = ST_HDR_TYPE;
      endcase
    end
  end

  always_comb begin
    q_push            = accept && (state == ST_PAYLOAD || state == ST_CHECK);
    q_entry.kind      = (state == ST_CHECK);
    q_entry.data      = (state == ST_PAYLOAD) ? s_tdata : 8'd0;
    q_entry.index     = (state == ST_PAYLOAD) ? index : 9'd0;
    q_entry.ptype     = ptype;
    q_entry.cmd_id    = cmd_id;
    q_entry.flag      = flag;
    q_entry.length    = length;
    q_entry.len_bad   = length > 16'(MaxPayload);
    q_entry.sum_bad   = sum != s_tdata;
    q_entry.code_mask = code_mask;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_HDR_TYPE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      case (state)
        ST_HDR_TYPE: begin
          ptype     <= s_tdata;
          sum       <= s_tdata;
          code_mask <= '0;
          index     <= '0;
        end
        ST_HDR_CMD_HI: begin
          cmd_id[15:8] <= s_tdata;
          sum          <= sum + s_tdata;
        end
        ST_HDR_CMD_LO: begin
          cmd_id[7:0] <= s_tdata;
          sum         <= sum + s_tdata;
        end
        ST_HDR_FLAG: begin
          flag <= s_tdata;
          sum  <= sum + s_tdata;
        end
        ST_HDR_LEN_LO: begin
          length[7:0] <= s_tdata;
          sum         <= sum + s_tdata;
        end
        ST_HDR_LEN_HI: begin
          length[15:8] <= s_tdata;
          remaining    <= {s_tdata, length[7:0]};
          sum          <= sum + s_tdata;
        end
        ST_PAYLOAD: begin
          sum       <= sum + s_tdata;
          code_mask <= code_mask | code_bit;
          remaining <= remaining - 16'd1;
          if (index != IndexMax) begin
            index <= index + 9'd1;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

/* hw/rtl/rpc_queue.sv */
module rpc_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  rpc_pkg::q_entry_t  push_entry,
  input  logic               pop,
  output rpc_pkg::q_entry_t  head,
  output rpc_pkg::q_status_t stat
);
  import rpc_pkg::*;

  q_entry_t         slots [QDepth];
  logic [QPtrW-1:0] wr_ptr;
  logic [QPtrW-1:0] rd_ptr;
  logic [QCntW-1:0] count;

  assign head       = slots[rd_ptr];
  assign stat.valid = (count != '0);
  assign stat.full  = (count == QCntW'(QDepth));

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPtrW'(QDepth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPtrW'(QDepth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* hw/rtl/rpc_back.sv */
module rpc_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [7:0]         cfg_data,
  input  rpc_pkg::q_entry_t  head,
  input  rpc_pkg::q_status_t stat,
  output logic               pop,
  output logic               m_tvalid,
  input  logic               m_tready,
  output rpc_pkg::out_data_t m_tdata,
  output logic               m_tlast
);
  import rpc_pkg::*;

  logic [7:0] sent_type;
  logic       expect_first;
  logic       load;
  logic [8:0] want_type;
  logic       firstish;
  logic       single_or_last;
  status_t    status;

  assign cfg_ready = 1'b1;
  assign load      = stat.valid && (!m_tvalid || m_tready);
  assign pop       = load;

  assign want_type      = {1'b0, sent_type} + 9'd1;
  assign firstish       = (head.flag == FLAG_SINGLE) || (head.flag == FLAG_FIRST);
  assign single_or_last = (head.flag == FLAG_SINGLE) || (head.flag == FLAG_LAST);

  // Checks run in a fixed priority: length, checksum, type, then sequence.
  always_comb begin
    if (head.len_bad) begin
      status = STATUS_LEN_BAD;
    end else if (head.sum_bad) begin
      status = STATUS_SUM_BAD;
    end else if ({1'b0, head.ptype} != want_type) begin
      if (head.ptype == TYPE_BUSY) begin
        status = STATUS_BUSY;
      end else if (head.ptype == TYPE_CMD_ERROR) begin
        status = STATUS_CMD_ERROR;
      end else if (head.ptype == TYPE_ECHO_A || head.ptype == TYPE_ECHO_B) begin
        status = STATUS_ECHO;
      end else begin
        status = STATUS_UNKNOWN;
      end
    end else if (expect_first != firstish) begin
      status = STATUS_FLAG_SEQ;
    end else begin
      status = STATUS_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sent_type    <= SentTypeReset;
      expect_first <= 1'b1;
      m_tvalid     <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        sent_type <= cfg_data;
      end
      if (load && head.kind) begin
        if (status == STATUS_OK) begin
          expect_first <= single_or_last;
        end else if (status == STATUS_FLAG_SEQ) begin
          expect_first <= 1'b1;
        end
      end
      if (load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tlast                   <= head.kind;
      m_tdata.pad               <= '0;
      m_tdata.payload_byte      <= head.data;
      m_tdata.payload_index     <= head.index;
      m_tdata.packet_type       <= head.ptype;
      m_tdata.command_id        <= head.cmd_id;
      m_tdata.continuation_flag <= head.flag;
      m_tdata.payload_length    <= head.length;
      if (head.kind) begin
        m_tdata.status            <= status;
        m_tdata.error_mask        <= (status == STATUS_CMD_ERROR) ? head.code_mask : '0;
        m_tdata.response_complete <= (status == STATUS_OK) && single_or_last;
      end else begin
        m_tdata.status            <= STATUS_OK;
        m_tdata.error_mask        <= '0;
        m_tdata.response_complete <= 1'b0;
      end
    end
  end

endmodule

/* tb/response_packet_checker_top_test.sv */
module response_packet_checker_top_test;
  import rpc_pkg::*;

  localparam int IdleMax       = 13;
  localparam int HoldOffCycles = 200;
  localparam int WatchdogLimit = 4000;
  localparam int DrainCycles   = 8;
  localparam int ReportLimit   = 10;
  localparam int RandomBytes   = 100;

  localparam logic [7:0] FLAG_MIDDLE  = 8'h02;
  localparam logic [7:0] TYPE_UNKNOWN = 8'hFF;

  typedef logic [7:0] byte_q_t[$];

  // One result transaction as the block should present it.
  typedef struct packed {
    logic      last;
    out_data_t word;
  } result_t;

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                s_tvalid  = 1'b0;
  logic [7:0]          s_tdata   = 8'h00;
  logic                cfg_valid = 1'b0;
  logic [7:0]          cfg_data  = 8'h00;
  logic                m_tready  = 1'b0;
  logic                s_tready;
  logic                cfg_ready;
  logic                m_tvalid;
  logic [OutDataW-1:0] m_tdata;
  logic                m_tlast;

  response_packet_checker_top dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 0;
  end

  // Deframer state as seen from outside, starting from its reset values.
  front_state_t hdr_pos    = ST_HDR_TYPE;
  logic [15:0]  left       = 16'h0000;
  logic [7:0]   run_sum    = 8'h00;
  logic [7:0]   pk_type    = 8'h00;
  logic [15:0]  pk_cmd     = 16'h0000;
  logic [7:0]   pk_flag    = 8'h00;
  logic [15:0]  pk_len     = 16'h0000;
  logic [31:0]  code_bits  = 32'h0;
  logic         want_first = 1'b1;
  logic [7:0]   sent_type  = SentTypeReset;

  result_t forwarded_items[$];

  int  mismatch_count = 0;
  int  bytes_in       = 0;
  int  payload_out    = 0;
  int  status_out     = 0;
  int  settings_used  = 0;
  int  status_seen[8] = '{default: 0};
  int  quiet_cycles   = 0;
  bit  fast_mode      = 1'b0;
  bit  tx_burst       = 1'b0;
  bit  rx_burst       = 1'b0;
  bit  hold_off_req   = 1'b0;

  // Advances the deframer by one received byte and queues what it forwards.
  function automatic void deframe_byte(logic [7:0] b);
    result_t     item;
    logic [15:0] pos;
    logic [7:0]  diff;
    status_t     st;
    item = '0;
    st = STATUS_OK;
    item.word.packet_type       = pk_type;
    item.word.command_id        = pk_cmd;
    item.word.continuation_flag = pk_flag;
    item.word.payload_length    = pk_len;
    case (hdr_pos)
      ST_PAYLOAD: begin
        pos = pk_len - left;
        run_sum = run_sum + b;
        if (b != 8'h00 && b <= ErrorCodeMax) code_bits[b - 8'd1] = 1'b1;
        item.word.payload_byte  = b;
        item.word.payload_index = (pos > 16'(IndexMax)) ? IndexMax : pos[8:0];
        left = left - 16'd1;
        if (left == 16'd0) hdr_pos = ST_CHECK;
        forwarded_items.push_back(item);
      end
      ST_CHECK: begin
        // A matching checksum byte cancels the running sum exactly.
        diff = run_sum - b;
        if (pk_len > 16'(MaxPayload)) begin
          st = STATUS_LEN_BAD;
        end else if (diff != 8'h00) begin
          st = STATUS_SUM_BAD;
        end else if ({1'b0, pk_type} != {1'b0, sent_type} + 9'd1) begin
          case (pk_type)
            TYPE_BUSY:                st = STATUS_BUSY;
            TYPE_CMD_ERROR:           st = STATUS_CMD_ERROR;
            TYPE_ECHO_A, TYPE_ECHO_B: st = STATUS_ECHO;
            default:                  st = STATUS_UNKNOWN;
          endcase
        end else if (want_first != (pk_flag == FLAG_SINGLE || pk_flag == FLAG_FIRST)) begin
          st = STATUS_FLAG_SEQ;
        end
        item.last                   = 1'b1;
        item.word.status            = st;
        item.word.error_mask        = (st == STATUS_CMD_ERROR) ? code_bits : 32'h0;
        item.word.response_complete = (st == STATUS_OK) &&
                                      (pk_flag == FLAG_SINGLE || pk_flag == FLAG_LAST);
        if (st == STATUS_OK) begin
          want_first = (pk_flag == FLAG_SINGLE || pk_flag == FLAG_LAST);
        end else if (st == STATUS_FLAG_SEQ) begin
          want_first = 1'b1;
        end
        status_seen[st]++;
        hdr_pos   = ST_HDR_TYPE;
        run_sum   = 8'h00;
        left      = 16'h0000;
        code_bits = 32'h0;
        forwarded_items.push_back(item);
      end
      default: begin
        run_sum = run_sum + b;
        case (hdr_pos)
          ST_HDR_TYPE: begin
            pk_type   = b;
            code_bits = 32'h0;
          end
          ST_HDR_CMD_HI: pk_cmd      = {b, 8'h00};
          ST_HDR_CMD_LO: pk_cmd[7:0] = b;
          ST_HDR_FLAG:   pk_flag     = b;
          ST_HDR_LEN_LO: pk_len      = {8'h00, b};
          default:       pk_len[15:8] = b;
        endcase
        if (hdr_pos == ST_HDR_LEN_HI) begin
          left    = pk_len;
          hdr_pos = (pk_len == 16'd0) ? ST_CHECK : ST_PAYLOAD;
        end else begin
          hdr_pos = front_state_t'(hdr_pos + 3'd1);
        end
      end
    endcase
  endfunction

  function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      mismatch_count++;
      if (mismatch_count <= ReportLimit) begin
        $display("Mismatch in %s of result %0d: expected %h, got %h",
                 name, payload_out + status_out, want, got);
      end
    end
  endfunction

  // Pops the oldest forwarded item and compares it with the accepted result.
  function automatic void check_result(logic last, out_data_t got);
    result_t want;
    if (last === 1'b1) status_out++;
    else payload_out++;
    if (forwarded_items.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= ReportLimit) begin
        $display("Unexpected result transaction: tlast %b, tdata %h", last, got);
      end
    end else begin
      want = forwarded_items.pop_front();
      compare_field("tlast", 32'(want.last), 32'(last));
      compare_field("payload_byte", 32'(want.word.payload_byte), 32'(got.payload_byte));
      compare_field("payload_index", 32'(want.word.payload_index),
                    32'(got.payload_index));
      compare_field("status", 32'(want.word.status), 32'(got.status));
      compare_field("packet_type", 32'(want.word.packet_type), 32'(got.packet_type));
      compare_field("command_id", 32'(want.word.command_id), 32'(got.command_id));
      compare_field("continuation_flag", 32'(want.word.continuation_flag),
                    32'(got.continuation_flag));
      compare_field("payload_length", 32'(want.word.payload_length),
                    32'(got.payload_length));
      compare_field("error_mask", want.word.error_mask, got.error_mask);
      compare_field("response_complete", 32'(want.word.response_complete),
                    32'(got.response_complete));
      compare_field("padding", 32'(want.word.pad), 32'(got.pad));
    end
  endfunction

  // Result side: random ready gaps, bursts without gaps, and one long hold-off
  // on request so the internal queue fills and the input stalls.
  always begin : result_sink
    int gap;
    if (rst) begin
      m_tready <= 1'b0;
      @(posedge clk);
    end else begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        m_tready <= 1'b0;
        repeat (HoldOffCycles) @(posedge clk);
      end
      gap = (fast_mode || rx_burst) ? 0 : $urandom_range(0, IdleMax);
      if (gap != 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      check_result(m_tlast, m_tdata);
      if ($urandom_range(0, 39) == 0) rx_burst = !rx_burst;
    end
  end

  // Ends the run when no transaction of any kind completes for too long.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("Timeout: no transaction for %0d cycles", WatchdogLimit);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = (fast_mode || tx_burst) ? 0 : $urandom_range(0, IdleMax);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    bytes_in++;
    deframe_byte(b);
  endtask

  task automatic send_packet(input logic [7:0] ptype, input logic [15:0] cmd,
                             input logic [7:0] flag, input byte_q_t body,
                             input bit bad_sum);
    logic [15:0] len;
    logic [7:0]  hdr[6];
    logic [7:0]  sum;
    len = 16'(body.size());
    hdr = '{ptype, cmd[15:8], cmd[7:0], flag, len[7:0], len[15:8]};
    sum = 8'h00;
    foreach (hdr[i]) begin
      sum = sum + hdr[i];
      send_byte(hdr[i]);
    end
    foreach (body[i]) begin
      sum = sum + body[i];
      send_byte(body[i]);
    end
    if (bad_sum) sum = sum + 8'($urandom_range(1, 255));
    send_byte(sum);
  endtask

  // Payload bytes lean toward small values so error codes show up often.
  function automatic byte_q_t rand_body(int n);
    byte_q_t q;
    repeat (n) begin
      q.push_back($urandom_range(0, 1) ? 8'($urandom_range(0, 40))
                                       : 8'($urandom_range(0, 255)));
    end
    return q;
  endfunction

  // A flag that is in sequence and brings the sequence back to a first packet.
  function automatic logic [7:0] lead_flag();
    return want_first ? FLAG_SINGLE : FLAG_LAST;
  endfunction

  task automatic settle();
    s_tvalid <= 1'b0;
    while (forwarded_items.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_sent_type(input logic [7:0] value);
    settle();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    sent_type = value;
    settings_used++;
  endtask

  // Mostly well-formed packets with random content; some carry a wrong type,
  // a broken flag sequence or a bad checksum.
  task automatic send_random_packet();
    logic [7:0]  ptype;
    logic [7:0]  flag;
    int          pick;
    int          len;
    pick = $urandom_range(0, 9);
    if (pick < 7) begin
      ptype = sent_type + 8'd1;
    end else if (pick == 7) begin
      case ($urandom_range(0, 3))
        0:       ptype = TYPE_BUSY;
        1:       ptype = TYPE_CMD_ERROR;
        2:       ptype = TYPE_ECHO_A;
        default: ptype = TYPE_ECHO_B;
      endcase
    end else begin
      ptype = 8'($urandom_range(0, 255));
    end
    pick = $urandom_range(0, 9);
    if (pick < 7) begin
      if (want_first) flag = $urandom_range(0, 1) ? FLAG_FIRST : FLAG_SINGLE;
      else flag = $urandom_range(0, 1) ? FLAG_LAST : FLAG_MIDDLE;
    end else if (pick < 9) begin
      flag = 8'($urandom_range(0, 3));
    end else begin
      flag = 8'($urandom_range(0, 255));
    end
    len = ($urandom_range(0, 15) == 0) ? $urandom_range(25, 100) : $urandom_range(0, 24);
    send_packet(ptype, 16'($urandom_range(0, 65535)), flag, rand_body(len),
                $urandom_range(0, 9) == 0);
  endtask

  // Raw bytes that may land anywhere in a packet; the length bytes are kept
  // small so a stray header stays short. Afterwards the open packet is
  // finished with random bytes so framing is back at a type byte.
  task automatic send_noise();
    logic [7:0] b;
    repeat ($urandom_range(1, 12)) begin
      case (hdr_pos)
        ST_HDR_LEN_LO: b = 8'($urandom_range(0, 15));
        ST_HDR_LEN_HI: b = 8'h00;
        default:       b = 8'($urandom_range(0, 255));
      endcase
      send_byte(b);
    end
    while (hdr_pos != ST_HDR_TYPE) send_byte(8'($urandom_range(0, 255)));
  endtask

  // Reset value of the command type; a full first, middle, last sequence.
  task automatic test_default_command_type();
    send_packet(8'h03, 16'h0000, FLAG_SINGLE, rand_body(0), 1'b0);
    send_packet(8'h03, 16'hFFFF, FLAG_FIRST, '{8'h00, 8'hFF}, 1'b0);
    send_packet(8'h03, 16'h8001, FLAG_MIDDLE, '{8'h80}, 1'b0);
    send_packet(8'h03, 16'h7FFE, FLAG_LAST, rand_body(0), 1'b0);
  endtask

  // Every status below the length check, and flag resynchronization.
  task automatic test_status_priority();
    write_sent_type(SentTypeReset);
    send_packet(TYPE_BUSY, 16'h0102, FLAG_SINGLE, rand_body(0), 1'b0);
    send_packet(TYPE_CMD_ERROR, 16'h0304, FLAG_SINGLE,
                '{8'd1, 8'd32, 8'd33, 8'd0, 8'd17, 8'hFF}, 1'b0);
    send_packet(TYPE_ECHO_A, 16'h0506, FLAG_SINGLE, rand_body(1), 1'b0);
    send_packet(TYPE_ECHO_B, 16'h0708, FLAG_SINGLE, rand_body(0), 1'b0);
    send_packet(TYPE_UNKNOWN, 16'h090A, FLAG_SINGLE, rand_body(2), 1'b0);
    send_packet(8'h03, 16'h0B0C, FLAG_SINGLE, rand_body(3), 1'b1);
    // Middle packet when a first one is due, then a first and an unexpected
    // single, then a last packet right after the resync.
    send_packet(8'h03, 16'h0D0E, FLAG_MIDDLE, rand_body(1), 1'b0);
    send_packet(8'h03, 16'h0F10, FLAG_FIRST, rand_body(1), 1'b0);
    send_packet(8'h03, 16'h1112, FLAG_SINGLE, rand_body(0), 1'b0);
    send_packet(8'h03, 16'h1314, FLAG_LAST, rand_body(0), 1'b0);
    send_packet(8'h03, 16'h1516, 8'h80, rand_body(0), 1'b0);
  endtask

  // An oversize payload that is still forwarded in full while its index
  // saturates at the top; the length check wins over checksum and type.
  // Idling is off to keep the run short.
  task automatic test_long_packets();
    settle();
    fast_mode = 1'b1;
    send_packet(TYPE_CMD_ERROR, 16'h5A5A, FLAG_SINGLE, rand_body(MaxPayload + 1), 1'b1);
    settle();
    fast_mode = 1'b0;
  endtask

  // Command type at zero, at 255 where no type can match, and just below.
  task automatic test_command_type_extremes();
    write_sent_type(8'h00);
    send_packet(TYPE_CMD_ERROR, 16'h0001, lead_flag(), rand_body(4), 1'b0);
    send_packet(TYPE_BUSY, 16'h0002, lead_flag(), rand_body(0), 1'b0);
    send_packet(TYPE_CMD_ERROR, 16'h0003, lead_flag(), rand_body(2), 1'b1);
    write_sent_type(8'hFF);
    send_packet(TYPE_BUSY, 16'h0004, lead_flag(), rand_body(0), 1'b0);
    send_packet(8'hFF, 16'h0005, lead_flag(), rand_body(1), 1'b0);
    send_packet(TYPE_CMD_ERROR, 16'h0006, lead_flag(), '{8'd2, 8'd31, 8'd7}, 1'b0);
    write_sent_type(8'hFE);
    send_packet(8'hFF, 16'h0007, lead_flag(), rand_body(3), 1'b0);
  endtask

  // The result side holds off while bytes keep coming without gaps.
  task automatic test_output_backpressure();
    settle();
    hold_off_req = 1'b1;
    tx_burst = 1'b1;
    repeat (4) send_packet(sent_type + 8'd1, 16'($urandom_range(0, 65535)),
                           lead_flag(), rand_body(6), 1'b0);
    tx_burst = 1'b0;
  endtask

  task automatic test_random_traffic();
    logic [7:0] type_choices[4];
    int         phase_end;
    type_choices = '{8'($urandom_range(0, 255)), SentTypeReset, 8'h00, 8'hFE};
    for (int p = 0; p < 4; p++) begin
      write_sent_type(type_choices[p]);
      phase_end = bytes_in + RandomBytes / 4;
      while (bytes_in < phase_end) begin
        if ($urandom_range(0, 7) == 0) tx_burst = !tx_burst;
        if ($urandom_range(0, 19) == 0) send_noise();
        else send_random_packet();
      end
      tx_burst = 1'b0;
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_default_command_type();
    test_status_priority();
    test_long_packets();
    test_command_type_extremes();
    test_output_backpressure();
    test_random_traffic();
    settle();
    $display("Run covered %0d bytes in, %0d payload and %0d status results, %0d type writes.",
             bytes_in, payload_out, status_out, settings_used);
    $display("Statuses ok/len/sum/busy/err/echo/unknown/flag: %0d %0d %0d %0d %0d %0d %0d %0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3],
             status_seen[4], status_seen[5], status_seen[6], status_seen[7]);
    if (mismatch_count == 0 && forwarded_items.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches, %0d results never arrived", mismatch_count,
               forwarded_items.size());
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
